FILE: src/jlex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlex_pkg: shared types and constants of the JSON lexer
// Token kinds, error codes, character codes, lexer modes, the item and
// result structs and the literal spelling table.
// ----------------------------------------------------------------------------
package jlex_pkg;

    // Counter width default and output field widths
    localparam int CNT_BITS_DEF = 24;
    localparam int OUT_W        = 24;
    localparam int S_DATA_W     = 8;
    localparam int S_USER_W     = 1;
    localparam int M_DATA_W     = 80;
    localparam int M_USER_W     = 4;
    localparam int RES_DEPTH    = 4;

    // Token kinds
    localparam logic [3:0] KIND_LBRACE   = 4'd0;
    localparam logic [3:0] KIND_RBRACE   = 4'd1;
    localparam logic [3:0] KIND_LBRACKET = 4'd2;
    localparam logic [3:0] KIND_RBRACKET = 4'd3;
    localparam logic [3:0] KIND_COMMA    = 4'd4;
    localparam logic [3:0] KIND_COLON    = 4'd5;
    localparam logic [3:0] KIND_INT      = 4'd6;
    localparam logic [3:0] KIND_FLOAT    = 4'd7;
    localparam logic [3:0] KIND_STRING   = 4'd8;
    localparam logic [3:0] KIND_NULL     = 4'd9;
    localparam logic [3:0] KIND_TRUE     = 4'd10;
    localparam logic [3:0] KIND_FALSE    = 4'd11;
    localparam logic [3:0] KIND_EOF      = 4'd12;
    localparam logic [3:0] KIND_ERROR    = 4'd13;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_MINUS      = 3'd1;
    localparam logic [2:0] ERR_DIGIT      = 3'd2;
    localparam logic [2:0] ERR_LITERAL    = 3'd3;
    localparam logic [2:0] ERR_UNTERM_STR = 3'd4;
    localparam logic [2:0] ERR_ESCAPE     = 3'd5;
    localparam logic [2:0] ERR_INVALID    = 3'd6;

    // Literal table indexes
    localparam logic [1:0] LIT_NULL  = 2'd0;
    localparam logic [1:0] LIT_TRUE  = 2'd1;
    localparam logic [1:0] LIT_FALSE = 2'd2;

    // Character codes
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_VT       = 8'h0B;
    localparam logic [7:0] CH_FF       = 8'h0C;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_9        = 8'h39;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_UP_E     = 8'h45;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LOW_B    = 8'h62;
    localparam logic [7:0] CH_LOW_E    = 8'h65;
    localparam logic [7:0] CH_LOW_F    = 8'h66;
    localparam logic [7:0] CH_LOW_N    = 8'h6E;
    localparam logic [7:0] CH_LOW_R    = 8'h72;
    localparam logic [7:0] CH_LOW_T    = 8'h74;
    localparam logic [7:0] CH_LOW_U    = 8'h75;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    // Lexer modes
    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_MINUS,
        MODE_INT,
        MODE_FRAC_FIRST,
        MODE_FRAC,
        MODE_EXP_SIGN,
        MODE_EXP_FIRST,
        MODE_EXP,
        MODE_LIT,
        MODE_STR,
        MODE_STR_ESC
    } mode_t;

    // One input item
    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_input;
    } item_t;

    // One result item
    typedef struct packed {
        logic [3:0]       token_kind;
        logic [2:0]       error_code;
        logic [OUT_W-1:0] line_number;
        logic [OUT_W-1:0] column_number;
        logic [OUT_W-1:0] token_length;
        logic             last_of_run;
    } res_t;

    // Length of a literal in characters
    function automatic logic [2:0] lit_len(input logic [1:0] idx);
        logic [2:0] len;
        len = (idx == LIT_FALSE) ? 3'd5 : 3'd4;
        return len;
    endfunction

    // Character of a literal at a position; zero past its end
    function automatic logic [7:0] lit_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (idx)
            LIT_NULL:
                case (pos)
                    3'd0: ch = "n";
                    3'd1: ch = "u";
                    3'd2: ch = "l";
                    3'd3: ch = "l";
                    default: ch = 8'h00;
                endcase
            LIT_TRUE:
                case (pos)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'h00;
                endcase
            LIT_FALSE:
                case (pos)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'h00;
                endcase
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: src/jlex_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlex_core: lexer state and per-item transition
// Holds mode, literal position, pending kind, line, column, length and the
// sticky error flag; decodes one item into up to two results in one pass.
// ----------------------------------------------------------------------------
module jlex_core #(
    parameter int CNT_W = jlex_pkg::CNT_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  jlex_pkg::item_t item,
    output jlex_pkg::res_t res0,
    output jlex_pkg::res_t res1,
    output logic [1:0]     res_cnt
);
    import jlex_pkg::*;

    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FOUR = CNT_W'(4);

    mode_t            mode_reg, mode_next;
    logic [2:0]       lit_pos_reg, lit_pos_next;
    logic [3:0]       pend_reg, pend_next;
    logic [CNT_W-1:0] line_reg, line_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic             err_reg, err_next;

    logic [CNT_W-1:0] col_sum;
    logic [CNT_W-1:0] col_fin;
    logic [CNT_W-1:0] len_grow;
    logic [CNT_W-1:0] col_base;
    logic [7:0]       b;
    logic             is_digit;
    logic             is_e;
    logic             esc_ok;
    logic [3:0]       lit_off;
    logic [1:0]       lit_idx;
    logic [2:0]       lit_pos_inc;
    logic             num_end;
    logic             run_idle;
    logic             ir_v;
    res_t             ir;
    res_t             r0;
    res_t             r1;
    logic [1:0]       cnt;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] x,
                                                 input logic [CNT_W-1:0] y);
        logic [CNT_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    // x + y + 1, saturating
    function automatic logic [CNT_W-1:0] sat_add1(input logic [CNT_W-1:0] x,
                                                  input logic [CNT_W-1:0] y);
        logic [CNT_W+1:0] s;
        s = {2'b00, x} + {2'b00, y} + (CNT_W+2)'(1);
        return (s[CNT_W+1:CNT_W] != 2'b00) ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic res_t mk_res(input logic [3:0] kind, input logic [2:0] code,
                                    input logic [CNT_W-1:0] line,
                                    input logic [CNT_W-1:0] col,
                                    input logic [CNT_W-1:0] len);
        res_t r;
        r.token_kind    = kind;
        r.error_code    = code;
        r.line_number   = OUT_W'(line);
        r.column_number = OUT_W'(col);
        r.token_length  = OUT_W'(len);
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    // Shared sums and byte classes
    assign b        = item.byte_value;
    assign col_sum  = sat_add(col_reg, len_reg);
    assign col_fin  = sat_add1(col_reg, len_reg);
    assign len_grow = sat_add(len_reg, CNT_ONE);
    assign is_digit = (b >= CH_0) && (b <= CH_9);
    assign is_e     = (b == CH_LOW_E) || (b == CH_UP_E);
    assign esc_ok   = (b == CH_LOW_U) || (b == CH_QUOTE) || (b == CH_BSLASH) ||
                      (b == CH_SLASH) || (b == CH_LOW_B) || (b == CH_LOW_F) ||
                      (b == CH_LOW_N) || (b == CH_LOW_R) || (b == CH_LOW_T);
    assign lit_off  = pend_reg - KIND_NULL;
    assign lit_idx  = (lit_off > 4'd2) ? LIT_NULL : lit_off[1:0];
    assign lit_pos_inc = lit_pos_reg + 3'd1;

    // Decode one item: next state and up to two results
    always_comb
    begin
        mode_next    = mode_reg;
        lit_pos_next = lit_pos_reg;
        pend_next    = pend_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        len_next     = len_reg;
        err_next     = err_reg;
        r0           = '0;
        r1           = '0;
        ir           = '0;
        ir_v         = 1'b0;
        cnt          = 2'd0;
        num_end      = 1'b0;
        run_idle     = 1'b0;
        col_base     = col_reg;

        if (!err_reg)
        begin
            if (item.end_of_input)
            begin
                // End mark: end of file, after closing an open number, or reject an unfinished token
                mode_next = MODE_IDLE;
                unique case (mode_reg)
                    MODE_MINUS:
                    begin
                        r0 = mk_res(KIND_ERROR, ERR_MINUS, line_reg, col_reg, '0);
                        cnt = 2'd1;
                        err_next = 1'b1;
                    end
                    MODE_INT, MODE_FRAC, MODE_EXP:
                    begin
                        r0 = mk_res(pend_reg, ERR_NONE, line_reg, col_reg, len_reg);
                        r1 = mk_res(KIND_EOF, ERR_NONE, line_reg, col_sum, '0);
                        cnt = 2'd2;
                        col_next = col_sum;
                        len_next = '0;
                    end
                    MODE_FRAC_FIRST, MODE_EXP_SIGN, MODE_EXP_FIRST:
                    begin
                        r0 = mk_res(KIND_ERROR, ERR_DIGIT, line_reg, col_reg, '0);
                        cnt = 2'd1;
                        err_next = 1'b1;
                    end
                    MODE_LIT:
                    begin
                        r0 = mk_res(KIND_ERROR, ERR_LITERAL, line_reg, col_reg, '0);
                        cnt = 2'd1;
                        err_next = 1'b1;
                    end
                    MODE_STR:
                    begin
                        r0 = mk_res(KIND_ERROR, ERR_UNTERM_STR, line_reg, col_reg, '0);
                        cnt = 2'd1;
                        err_next = 1'b1;
                    end
                    MODE_STR_ESC:
                    begin
                        r0 = mk_res(KIND_ERROR, ERR_ESCAPE, line_reg, col_fin, '0);
                        cnt = 2'd1;
                        err_next = 1'b1;
                    end
                    default:
                    begin
                        r0 = mk_res(KIND_EOF, ERR_NONE, line_reg, col_reg, '0);
                        cnt = 2'd1;
                    end
                endcase
            end
            else
            begin
                // Byte inside or outside a token
                unique case (mode_reg)
                    MODE_MINUS:
                        if (is_digit)
                        begin
                            len_next = len_grow;
                            mode_next = MODE_INT;
                        end
                        else
                        begin
                            r0 = mk_res(KIND_ERROR, ERR_MINUS, line_reg, col_reg, '0);
                            cnt = 2'd1;
                            err_next = 1'b1;
                        end
                    MODE_INT:
                        if (is_digit)
                        begin
                            len_next = len_grow;
                        end
                        else if (b == CH_DOT)
                        begin
                            pend_next = KIND_FLOAT;
                            len_next = len_grow;
                            mode_next = MODE_FRAC_FIRST;
                        end
                        else if (is_e)
                        begin
                            pend_next = KIND_FLOAT;
                            len_next = len_grow;
                            mode_next = MODE_EXP_SIGN;
                        end
                        else
                        begin
                            num_end = 1'b1;
                        end
                    MODE_FRAC:
                        if (is_digit)
                        begin
                            len_next = len_grow;
                        end
                        else if (is_e)
                        begin
                            len_next = len_grow;
                            mode_next = MODE_EXP_SIGN;
                        end
                        else
                        begin
                            num_end = 1'b1;
                        end
                    MODE_EXP:
                        if (is_digit)
                        begin
                            len_next = len_grow;
                        end
                        else
                        begin
                            num_end = 1'b1;
                        end
                    MODE_FRAC_FIRST:
                        if (is_digit)
                        begin
                            len_next = len_grow;
                            mode_next = MODE_FRAC;
                        end
                        else
                        begin
                            r0 = mk_res(KIND_ERROR, ERR_DIGIT, line_reg, col_reg, '0);
                            cnt = 2'd1;
                            err_next = 1'b1;
                        end
                    MODE_EXP_SIGN:
                        if ((b == CH_PLUS) || (b == CH_MINUS))
                        begin
                            len_next = len_grow;
                            mode_next = MODE_EXP_FIRST;
                        end
                        else if (is_digit)
                        begin
                            len_next = len_grow;
                            mode_next = MODE_EXP;
                        end
                        else
                        begin
                            r0 = mk_res(KIND_ERROR, ERR_DIGIT, line_reg, col_reg, '0);
                            cnt = 2'd1;
                            err_next = 1'b1;
                        end
                    MODE_EXP_FIRST:
                        if (is_digit)
                        begin
                            len_next = len_grow;
                            mode_next = MODE_EXP;
                        end
                        else
                        begin
                            r0 = mk_res(KIND_ERROR, ERR_DIGIT, line_reg, col_reg, '0);
                            cnt = 2'd1;
                            err_next = 1'b1;
                        end
                    MODE_LIT:
                        if ((lit_pos_reg >= lit_len(lit_idx)) ||
                            (b != lit_char(lit_idx, lit_pos_reg)))
                        begin
                            r0 = mk_res(KIND_ERROR, ERR_LITERAL, line_reg, col_reg, '0);
                            cnt = 2'd1;
                            err_next = 1'b1;
                        end
                        else
                        begin
                            len_next = len_grow;
                            lit_pos_next = lit_pos_inc;
                            if (lit_pos_inc >= lit_len(lit_idx))
                            begin
                                r0 = mk_res(pend_reg, ERR_NONE, line_reg, col_reg, len_grow);
                                cnt = 2'd1;
                                col_next = col_fin;
                                len_next = '0;
                                mode_next = MODE_IDLE;
                            end
                        end
                    MODE_STR:
                    begin
                        len_next = len_grow;
                        mode_next = (b == CH_BSLASH) ? MODE_STR_ESC : MODE_STR;
                        if (b == CH_QUOTE)
                        begin
                            r0 = mk_res(KIND_STRING, ERR_NONE, line_reg, col_reg, len_grow);
                            cnt = 2'd1;
                            col_next = col_fin;
                            len_next = '0;
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_STR_ESC:
                    begin
                        len_next = len_grow;
                        mode_next = MODE_STR;
                        if (!esc_ok)
                        begin
                            r0 = mk_res(KIND_ERROR, ERR_ESCAPE, line_reg, col_fin, '0);
                            cnt = 2'd1;
                            err_next = 1'b1;
                        end
                    end
                    default:
                        run_idle = 1'b1;
                endcase

                // Close a number on the byte after it
                if (num_end)
                begin
                    r0 = mk_res(pend_reg, ERR_NONE, line_reg, col_reg, len_reg);
                    cnt = 2'd1;
                    run_idle = 1'b1;
                    col_base = col_sum;
                end

                // Byte between tokens
                if (run_idle)
                begin
                    mode_next = MODE_IDLE;
                    col_next = col_base;
                    len_next = '0;
                    case (b) inside
                        CH_LF:
                        begin
                            line_next = sat_add(line_reg, CNT_ONE);
                            col_next = CNT_ONE;
                        end
                        CH_TAB:
                            col_next = sat_add(col_base, CNT_FOUR);
                        CH_SPACE, CH_VT, CH_FF, CH_CR:
                            col_next = sat_add(col_base, CNT_ONE);
                        CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET, CH_COMMA,
                        CH_COLON:
                        begin
                            ir = mk_res(KIND_LBRACE, ERR_NONE, line_reg, col_base, CNT_ONE);
                            case (b)
                                CH_RBRACE:   ir.token_kind = KIND_RBRACE;
                                CH_LBRACKET: ir.token_kind = KIND_LBRACKET;
                                CH_RBRACKET: ir.token_kind = KIND_RBRACKET;
                                CH_COMMA:    ir.token_kind = KIND_COMMA;
                                CH_COLON:    ir.token_kind = KIND_COLON;
                                default:     ir.token_kind = KIND_LBRACE;
                            endcase
                            ir_v = 1'b1;
                            col_next = sat_add(col_base, CNT_ONE);
                        end
                        [CH_0:CH_9], CH_MINUS:
                        begin
                            mode_next = (b == CH_MINUS) ? MODE_MINUS : MODE_INT;
                            pend_next = KIND_INT;
                            len_next = CNT_ONE;
                            lit_pos_next = 3'd1;
                        end
                        CH_QUOTE:
                        begin
                            mode_next = MODE_STR;
                            pend_next = KIND_STRING;
                            len_next = CNT_ONE;
                            lit_pos_next = 3'd1;
                        end
                        CH_LOW_N, CH_LOW_T, CH_LOW_F:
                        begin
                            mode_next = MODE_LIT;
                            pend_next = (b == CH_LOW_N) ? KIND_NULL :
                                        (b == CH_LOW_T) ? KIND_TRUE : KIND_FALSE;
                            len_next = CNT_ONE;
                            lit_pos_next = 3'd1;
                        end
                        default:
                        begin
                            ir = mk_res(KIND_ERROR, ERR_INVALID, line_reg, col_base, '0);
                            ir_v = 1'b1;
                            err_next = 1'b1;
                        end
                    endcase
                    if (ir_v)
                    begin
                        if (num_end)
                            r1 = ir;
                        else
                            r0 = ir;
                        cnt = cnt + 2'd1;
                    end
                end
            end
        end

        // Mark the final result of the item
        if (cnt == 2'd1)
            r0.last_of_run = 1'b1;
        if (cnt == 2'd2)
            r1.last_of_run = 1'b1;
    end

    assign res0    = r0;
    assign res1    = r1;
    assign res_cnt = cnt;

    // Advance the lexer state on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            lit_pos_reg <= 3'd0;
            pend_reg    <= 4'd0;
            line_reg    <= CNT_ONE;
            col_reg     <= CNT_ONE;
            len_reg     <= '0;
            err_reg     <= 1'b0;
        end
        else if (item_valid)
        begin
            mode_reg    <= mode_next;
            lit_pos_reg <= lit_pos_next;
            pend_reg    <= pend_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            len_reg     <= len_next;
            err_reg     <= err_next;
        end
    end

    // A stopped lexer produces nothing
    a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> res_cnt == 2'd0)
        else $error("results produced after a sticky error");

    // An open token always has a nonzero length
    a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_IDLE) |-> (len_reg != '0))
        else $error("open token with zero length");

    // Line and column never drop to zero
    a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (line_reg != '0) && (col_reg != '0))
        else $error("line or column counter reached zero");

endmodule

FILE: src/jlex_res_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlex_res_buf: result queue
// Four-entry queue that takes up to two results per cycle while it has room
// and hands one result per cycle to the output channel while it is ready.
// ----------------------------------------------------------------------------
module jlex_res_buf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  jlex_pkg::res_t res0,
    input  jlex_pkg::res_t res1,
    input  logic [1:0]     res_cnt,
    output logic           room,
    output logic           head_valid,
    input  logic           head_ready,
    output jlex_pkg::res_t head
);
    import jlex_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(RES_DEPTH - 2);

    res_t             fifo_reg [RES_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       push_cnt;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_inc;

    assign push_cnt   = push ? res_cnt : 2'd0;
    assign pop        = head_valid && head_ready;
    assign head_valid = (count_reg != '0);
    assign head       = fifo_reg[rd_ptr_reg];
    assign room       = (count_reg <= ROOM_MAX);
    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the results of the item
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            fifo_reg[wr_ptr_reg] <= res0;
        if (push_cnt == 2'd2)
            fifo_reg[wr_ptr_inc] <= res1;
    end

    // Fill level stays within the queue
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RES_DEPTH))
        else $error("result queue overfilled");

    // Results arrive only when two slots are free
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != 2'd0) |-> room)
        else $error("results pushed without room");

    // A lone pop drains exactly one entry
    a_pop_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (push_cnt == 2'd0)) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("fill level wrong after pop");

endmodule

FILE: src/json_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_lexer: streaming JSON tokenizer
// Turns a byte stream into JSON tokens with start line, start column and
// length; reports the first error and then stays silent until reset.
//
//   channel   direction   handshake            payload
//   s_*       in          s_tvalid/s_tready    byte_value, end_of_input
//   m_*       out         m_tvalid/m_tready    token result, m_tlast per item
//
// One item is taken per cycle while the result queue has room; its results
// pass through the input register and then the result queue.
// The output sends one result per cycle while m_tready is high; an item
// with two results (a number closed by a punctuation or invalid byte, or
// a number then end of file) is absorbed by the four-entry result queue.
// Reset returns the lexer to line 1, column 1 with no token open; no
// clearing pass follows. A stalled output fills the queue and then holds
// s_tready low.
// ----------------------------------------------------------------------------
module json_lexer #(
    parameter int COUNTER_BITS = jlex_pkg::CNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [jlex_pkg::S_DATA_W-1:0] s_tdata,  // [7:0] byte_value
    input  logic [jlex_pkg::S_USER_W-1:0] s_tuser,  // [0] end_of_input
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] error_code, [26:3] line_number, [50:27] column_number,
    // [74:51] token_length, [79:75] zero
    output logic [jlex_pkg::M_DATA_W-1:0] m_tdata,
    output logic [jlex_pkg::M_USER_W-1:0] m_tuser,  // [3:0] token_kind
    output logic                          m_tlast   // last_of_run
);
    import jlex_pkg::*;

    localparam int PAD_W = M_DATA_W - 3 - 3 * OUT_W;

    logic  in_valid_reg, in_valid_next;
    item_t item_reg;
    logic  s_accept;
    logic  advance;
    logic  room;
    res_t  res0;
    res_t  res1;
    logic [1:0] res_cnt;
    res_t  head;

    // Input register: take a new item when none is held or the held one moves on
    assign s_tready = !in_valid_reg || room;
    assign s_accept = s_tvalid && s_tready;
    assign advance  = in_valid_reg && room;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.byte_value   <= s_tdata[7:0];
            item_reg.end_of_input <= s_tuser[0];
        end
    end

    // Lexer state and decode
    jlex_core #(
        .CNT_W (COUNTER_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (advance),
        .item       (item_reg),
        .res0       (res0),
        .res1       (res1),
        .res_cnt    (res_cnt)
    );

    // Result queue
    jlex_res_buf u_res_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (advance),
        .res0       (res0),
        .res1       (res1),
        .res_cnt    (res_cnt),
        .room       (room),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head       (head)
    );

    // Pack the head result onto the output channel
    assign m_tdata = {{PAD_W{1'b0}}, head.token_length, head.column_number,
                      head.line_number, head.error_code};
    assign m_tuser = head.token_kind;
    assign m_tlast = head.last_of_run;

endmodule
